/* src/dcfp_pkg.sv */
// Shared types and constants for the drive command frame parser.
// Depends on nothing; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package dcfp_pkg;

  // Reset value of the sync byte; the sync byte seen twice in a row resets the frame position.
  localparam logic [7:0] SYNC_RESET = 8'h80;

  // Frame position of the last byte of a frame.
  localparam logic [3:0] FRAME_LAST = 4'd11;

  // Frame position bits that mark the fourth byte of a pair.
  localparam logic [1:0] PAIR_LAST = 2'd3;

  typedef logic [3:0]  frame_pos_t;
  typedef logic [1:0]  pair_idx_t;
  typedef logic [15:0] drive_word_t;

  // Pair update handed from the frame tracker to the result register.
  typedef struct packed {
    logic        emit;
    pair_idx_t   pair;
    drive_word_t first_raw;
    drive_word_t second_raw;
  } pair_update_t;

endpackage

/* src/drive_command_frame_parser.sv */
// Top level of the drive command frame parser: sync register and channel handshakes.
// Depends on dcfp_pkg, dcfp_tracker and dcfp_result_reg.
//
// Usage:
//   Received bytes enter on in_rx_byte with in_valid; a byte transfers at a
//   rising edge with in_valid high and in_stall low. Every fourth byte of a
//   twelve-byte frame produces one pair update on the out_ channel, which
//   transfers at an edge with out_valid high and out_stall low.
//   Two sync bytes in a row restart the frame and produce nothing.
//   The sync byte is written through cfg_valid/cfg_data; cfg_ready is always
//   high, and a write takes effect for the next byte.
//   A pair update is registered and appears in the cycle after its fourth byte transfers.
//   Throughput: one byte per cycle while the single result register holds no stalled result.
//   While a held result is stalled, in_stall is high and no byte transfers;
//   in any other cycle a byte is taken, even while the result waits.
//   Reset (rst_n low, synchronous) restores the sync byte to 0x80, clears the
//   frame position, the previous byte and the result valid.
`timescale 1ns / 1ps

module drive_command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // Pair update channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_pair_index,
  output logic [15:0] out_first_magnitude,
  output logic        out_first_negative,
  output logic [15:0] out_second_magnitude,
  output logic        out_second_negative,
  // Sync byte configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]             sync_byte_r;
  logic                   accept;
  logic                   full_stalled;
  dcfp_pkg::pair_update_t update;

  // Sync byte register, always ready for a transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= dcfp_pkg::SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_byte_r <= cfg_data;
    end
  end

  // A byte transfers unless the result register holds a stalled result.
  assign in_stall = full_stalled;
  assign accept   = in_valid && !in_stall;

  dcfp_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .sync_byte (sync_byte_r),
    .update    (update)
  );

  dcfp_result_reg u_result (
    .clk                  (clk),
    .rst_n                (rst_n),
    .update               (update),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .full_stalled         (full_stalled),
    .out_pair_index       (out_pair_index),
    .out_first_magnitude  (out_first_magnitude),
    .out_first_negative   (out_first_negative),
    .out_second_magnitude (out_second_magnitude),
    .out_second_negative  (out_second_negative)
  );

endmodule

/* src/dcfp_tracker.sv */
// Frame position tracking, sync detection and byte history for one frame pair.
// Depends on dcfp_pkg for the frame constants and the pair update struct.
`timescale 1ns / 1ps

module dcfp_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            sync_byte,
  output dcfp_pkg::pair_update_t update
);

  dcfp_pkg::frame_pos_t pos_r;
  dcfp_pkg::frame_pos_t pos_nxt;
  logic [7:0]           prev_r;
  // The three most recent data bytes of the current pair, oldest in the top byte.
  logic [23:0]          hist_r;
  logic [23:0]          hist_nxt;
  logic                 sync_hit;
  logic                 data_write;

  // Two sync bytes in a row restart the frame; positions beyond the frame are dropped.
  assign sync_hit   = (prev_r == sync_byte) && (rx_byte == sync_byte);
  assign data_write = !sync_hit && (pos_r <= dcfp_pkg::FRAME_LAST);

  // Next position and byte history for an accepted byte.
  always_comb begin
    pos_nxt  = pos_r;
    hist_nxt = hist_r;
    priority if (!data_write) begin
      pos_nxt = '0;
    end else begin
      hist_nxt = {hist_r[15:0], rx_byte};
      if (pos_r == dcfp_pkg::FRAME_LAST) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  // A pair is complete on its fourth byte; the value words come from the history.
  always_comb begin
    update.emit       = accept && data_write && (pos_r[1:0] == dcfp_pkg::PAIR_LAST);
    update.pair       = pos_r[3:2];
    update.first_raw  = {hist_r[15:8], hist_r[23:16]};
    update.second_raw = {rx_byte, hist_r[7:0]};
  end

  // State registers; the history carries data only and needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      prev_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

/* src/dcfp_result_reg.sv */
// Result register: splits each drive value into magnitude and sign and holds it.
// Depends on dcfp_pkg for the pair update struct and word types.
`timescale 1ns / 1ps

module dcfp_result_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dcfp_pkg::pair_update_t update,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   full_stalled,
  output logic [1:0]             out_pair_index,
  output logic [15:0]            out_first_magnitude,
  output logic                   out_first_negative,
  output logic [15:0]            out_second_magnitude,
  output logic                   out_second_negative
);

  logic                  valid_r;
  logic                  valid_nxt;
  dcfp_pkg::pair_idx_t   pair_r;
  dcfp_pkg::drive_word_t first_mag_r;
  dcfp_pkg::drive_word_t first_mag_nxt;
  logic                  first_neg_r;
  dcfp_pkg::drive_word_t second_mag_r;
  dcfp_pkg::drive_word_t second_mag_nxt;
  logic                  second_neg_r;

  // Two's complement magnitude; the most negative value yields 0x8000.
  assign first_mag_nxt  = update.first_raw[15]  ? (16'd0 - update.first_raw)
                                                : update.first_raw;
  assign second_mag_nxt = update.second_raw[15] ? (16'd0 - update.second_raw)
                                                : update.second_raw;

  // The register is busy only while it holds a result the receiver stalls.
  assign full_stalled = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    priority if (update.emit) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only when a new pair update arrives.
  always_ff @(posedge clk) begin
    if (update.emit) begin
      pair_r       <= update.pair;
      first_mag_r  <= first_mag_nxt;
      first_neg_r  <= update.first_raw[15];
      second_mag_r <= second_mag_nxt;
      second_neg_r <= update.second_raw[15];
    end
  end

  assign out_valid            = valid_r;
  assign out_pair_index       = pair_r;
  assign out_first_magnitude  = first_mag_r;
  assign out_first_negative   = first_neg_r;
  assign out_second_magnitude = second_mag_r;
  assign out_second_negative  = second_neg_r;

endmodule

/* verif/drive_update_check_pkg.sv */
// Scoreboard for the drive command frame parser testbench: frame predictor and result checks.
// Depends on dcfp_pkg for the frame constants and the drive word types.
`timescale 1ns / 1ps

package drive_update_check_pkg;
  import dcfp_pkg::*;

  // One pair update as seen on the result channel.
  typedef struct packed {
    pair_idx_t   pair;
    drive_word_t first_mag;
    logic        first_neg;
    drive_word_t second_mag;
    logic        second_neg;
  } drive_pair_t;

  localparam int MAX_REPORTS = 10;

  class pair_update_scoreboard;
    logic [7:0]  sync_value;
    frame_pos_t  frame_pos;
    logic [7:0]  last_byte;
    drive_word_t drive_words [6];
    drive_pair_t pending_updates [$];
    int          failures;

    function new();
      sync_value = SYNC_RESET;
      frame_pos  = '0;
      last_byte  = '0;
      failures   = 0;
      foreach (drive_words[i]) drive_words[i] = '0;
    endfunction

    function void set_sync(logic [7:0] value);
      sync_value = value;
    endfunction

    function int pending_count();
      return pending_updates.size();
    endfunction

    // Absolute value of a two's-complement word; the most negative word keeps its bits.
    function drive_word_t magnitude_of(drive_word_t raw);
      drive_word_t flipped;
      flipped = ~raw + 16'd1;
      return raw[15] ? flipped : raw;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // Advances the frame state by one transferred byte and queues the pair update it causes.
    function void note_byte(logic [7:0] value);
      logic [7:0]  prior;
      logic [2:0]  entry;
      pair_idx_t   pair;
      drive_pair_t upd;
      prior     = last_byte;
      last_byte = value;

      // Two sync bytes in a row restart the frame.
      if (prior == sync_value && value == sync_value) begin
        frame_pos = '0;
        return;
      end
      if (frame_pos > FRAME_LAST) begin
        frame_pos = '0;
        return;
      end

      // Little-endian assembly into the word store.
      entry = frame_pos[3:1];
      if (frame_pos[0]) begin
        drive_words[entry][15:8] = value;
      end else begin
        drive_words[entry][7:0] = value;
      end

      if (frame_pos[1:0] != PAIR_LAST) begin
        frame_pos = frame_pos + 4'd1;
        return;
      end

      // The fourth byte of a pair completes one update.
      pair           = frame_pos[3:2];
      upd.pair       = pair;
      upd.first_mag  = magnitude_of(drive_words[{pair, 1'b0}]);
      upd.first_neg  = drive_words[{pair, 1'b0}][15];
      upd.second_mag = magnitude_of(drive_words[{pair, 1'b1}]);
      upd.second_neg = drive_words[{pair, 1'b1}][15];
      pending_updates.push_back(upd);
      frame_pos = (frame_pos == FRAME_LAST) ? 4'd0 : frame_pos + 4'd1;
    endfunction

    // Compares one transferred update with the oldest expected one.
    function void check_update(drive_pair_t got);
      drive_pair_t want;
      bit          same;
      if (pending_updates.size() == 0) begin
        flag($sformatf("unexpected update pair=%0d mag=%0d/%0d neg=%0b/%0b",
                       got.pair, got.first_mag, got.second_mag, got.first_neg,
                       got.second_neg));
        return;
      end
      want = pending_updates.pop_front();
      same = (got.pair === want.pair) && (got.first_mag === want.first_mag) &&
             (got.first_neg === want.first_neg) && (got.second_mag === want.second_mag) &&
             (got.second_neg === want.second_neg);
      if (!same) begin
        flag($sformatf({"expected pair=%0d mag=%0d/%0d neg=%0b/%0b, ",
                        "got pair=%0d mag=%0d/%0d neg=%0b/%0b"},
                       want.pair, want.first_mag, want.second_mag, want.first_neg,
                       want.second_neg, got.pair, got.first_mag, got.second_mag,
                       got.first_neg, got.second_neg));
      end
    endfunction
  endclass

endpackage

/* verif/testbench.sv */
// Top-level testbench for drive_command_frame_parser: stimulus, handshakes and final verdict.
// Depends on dcfp_pkg, drive_update_check_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import dcfp_pkg::*;
  import drive_update_check_pkg::*;

  localparam int MAX_GAP     = 10;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 4;
  localparam int PHASE_ITEMS = 136;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_pair_index;
  logic [15:0] out_first_magnitude;
  logic        out_first_negative;
  logic [15:0] out_second_magnitude;
  logic        out_second_negative;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  pair_update_scoreboard sb;
  bit tx_quiet  = 1'b0;
  bit rx_quiet  = 1'b0;
  bit long_hold = 1'b0;
  int cycles    = 0;

  // Frame of extreme words, repeated sync bytes, and a sync pair inside a pair.
  logic [7:0] opening_bytes [0:21] = '{
    8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h80,
    8'h80, 8'h80,
    8'h11, 8'h22, 8'h80, 8'h80,
    8'h34, 8'h12, 8'hCD, 8'hAB
  };

  drive_command_frame_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pair_index       (out_pair_index),
    .out_first_magnitude  (out_first_magnitude),
    .out_first_negative   (out_first_negative),
    .out_second_magnitude (out_second_magnitude),
    .out_second_negative  (out_second_negative),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one byte after a random gap and waits for its transfer.
  // Handshakes are sampled at the falling edge, where all inputs and outputs are settled.
  task automatic send_byte(input logic [7:0] value);
    int   gap;
    logic taken;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    do begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      if (taken) sb.note_byte(value);
      @(posedge clk);
    end while (!taken);
  endtask

  // Stops offering bytes until every expected update has been transferred.
  task automatic drain_updates();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      if (taken) sb.set_sync(value);
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // Byte values weighted toward the word extremes and the current sync byte.
  function automatic logic [7:0] pick_byte();
    logic [7:0] any;
    any = 8'($urandom);
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return sb.sync_value;
      default: return any;
    endcase
  endfunction

  // A sync pair followed by the given number of data bytes.
  task automatic send_frame(input int data_bytes);
    send_byte(sb.sync_value);
    send_byte(sb.sync_value);
    for (int k = 0; k < data_bytes; k++) send_byte(pick_byte());
  endtask

  // Mostly whole frames with random content; some loose bytes and cut-off frames.
  task automatic run_phase(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 6);
          repeat (len) send_byte(pick_byte());
          sent += len;
        end
        1: begin
          len = $urandom_range(1, 11);
          send_frame(len);
          sent += len + 2;
        end
        default: begin
          len = 12 * $urandom_range(1, 3);
          send_frame(len);
          sent += len + 2;
        end
      endcase
    end
  endtask

  // Result side: random stall before each transfer, one long hold on request.
  initial begin : result_sink
    int          hold;
    logic        taken;
    drive_pair_t got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = out_valid && !out_stall;
        if (taken) begin
          got.pair       = out_pair_index;
          got.first_mag  = out_first_magnitude;
          got.first_neg  = out_first_negative;
          got.second_mag = out_second_magnitude;
          got.second_neg = out_second_negative;
          sb.check_update(got);
        end
        @(posedge clk);
      end while (!taken);
    end
  end

  // Main sequence: reset, directed bytes, then random phases under several sync values.
  initial begin
    logic [7:0] next_sync;
    sb = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    cfg_valid  <= 1'b0;
    cfg_data   <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    for (int p = 0; p < 5; p++) begin
      drain_updates();
      if (p > 0) begin
        case (p)
          1: next_sync = 8'h00;
          2: next_sync = 8'hFF;
          3: next_sync = 8'($urandom_range(1, 254));
          default: next_sync = SYNC_RESET;
        endcase
        write_sync(next_sync);
      end
      // Phase 2 sends back to back while the receiver holds off; phase 3 never stalls.
      tx_quiet = (p == 2);
      rx_quiet = (p == 3);
      if (p == 2) long_hold = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    drain_updates();
    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
